// ===== rtl/dfrw_pkg.sv =====
// Package: constants, types and register codes of the delayed-feedback random walk.
`timescale 1ns / 1ps
package dfrw_pkg;

    // Walk parameters
    localparam int HALF_RANGE = 10;
    localparam int DELAY_A    = 4;
    localparam int DELAY_B    = 0;
    localparam int HIST_DEPTH = ((DELAY_A > DELAY_B) ? DELAY_A : DELAY_B) + 1;

    // Internal position width: enough for +/-HALF_RANGE in two's complement
    localparam int POS_W = $clog2(HALF_RANGE + 1) + 1;
    // Compare width: covers the position and the negated threshold
    localparam int CMP_W = ((POS_W > 7) ? POS_W : 7) + 1;

    // Field widths
    localparam int FRAC_W     = 16;
    localparam int OUT_W      = 5;
    localparam int THR_W      = 6;
    localparam int BIAS_W     = 15;
    localparam int PROB_W     = FRAC_W + 1;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 8;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [PROB_W-1:0] HALF_PROB  = PROB_W'(32768);
    localparam logic [BIAS_W-1:0] BIAS_RESET = BIAS_W'(32440);
    localparam logic [THR_W-1:0]  THR_RESET  = '0;

    localparam logic signed [POS_W:0] POS_MAX_WIDE = (POS_W + 1)'(HALF_RANGE);
    localparam logic signed [POS_W:0] POS_MIN_WIDE = -((POS_W + 1)'(HALF_RANGE));

    typedef logic signed [POS_W-1:0] pos_t;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD = CFG_IDX_W'(0),
        REG_BIAS      = CFG_IDX_W'(1)
    } reg_idx_t;

    typedef struct packed {
        logic [THR_W-1:0]  threshold;
        logic [BIAS_W-1:0] bias;
    } cfg_t;

    typedef struct packed {
        logic drive_a;
        logic drive_b;
        logic step_up;
    } step_stat_t;

endpackage

// ===== rtl/dfrw_cell.sv =====
// One history cell: holds one past position and hands it on at each step.
`timescale 1ns / 1ps
module dfrw_cell
    import dfrw_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic shift_en,
    input  pos_t rst_value,
    input  pos_t d_in,
    output pos_t q_out
);

    pos_t pos_reg;
    pos_t pos_next;

    always_comb begin
        pos_next = pos_reg;
        if (shift_en) begin
            pos_next = d_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= rst_value;
        end else begin
            pos_reg <= pos_next;
        end
    end

    assign q_out = pos_reg;

endmodule

// ===== rtl/dfrw_step.sv =====
// Step logic: drive terms, up-probability, compare and saturating move.
`timescale 1ns / 1ps
module dfrw_step
    import dfrw_pkg::*;
(
    input  cfg_t               cfg,
    input  logic [FRAC_W-1:0]  frac,
    input  pos_t               pos_now,
    input  pos_t               pos_dly_a,
    input  pos_t               pos_dly_b,
    output pos_t               pos_new,
    output step_stat_t         stat
);

    logic signed [CMP_W-1:0] thr_s;
    logic signed [CMP_W-1:0] dly_a_s;
    logic signed [CMP_W-1:0] dly_b_s;
    logic                    drive_a;
    logic                    drive_b;
    logic [PROB_W-1:0]       prob;
    logic                    step_up;
    logic signed [POS_W:0]   wide;

    assign thr_s   = signed'(CMP_W'(cfg.threshold));
    assign dly_a_s = CMP_W'(pos_dly_a);
    assign dly_b_s = CMP_W'(pos_dly_b);
    assign drive_a = (dly_a_s <= thr_s);
    assign drive_b = (dly_b_s >= -thr_s);

    always_comb begin
        case ({drive_a, drive_b})
            2'b10:   prob = HALF_PROB + PROB_W'(cfg.bias);
            2'b01:   prob = HALF_PROB - PROB_W'(cfg.bias);
            default: prob = HALF_PROB;
        endcase
    end

    assign step_up = (PROB_W'(frac) < prob);

    always_comb begin
        if (step_up) begin
            wide = (POS_W + 1)'(pos_now) + (POS_W + 1)'(1);
            if (wide > POS_MAX_WIDE) begin
                wide = POS_MAX_WIDE;
            end
        end else begin
            wide = (POS_W + 1)'(pos_now) - (POS_W + 1)'(1);
            if (wide < POS_MIN_WIDE) begin
                wide = POS_MIN_WIDE;
            end
        end
    end

    assign pos_new = wide[POS_W-1:0];

    assign stat.drive_a = drive_a;
    assign stat.drive_b = drive_b;
    assign stat.step_up = step_up;

endmodule

// ===== rtl/delayed_feedback_random_walk.sv =====
// Top level: bounded random walk with delayed step-function feedback.
`timescale 1ns / 1ps
// Each input word carries one uniform random fraction (Q0.16) and yields one
// output word holding the new walk position (5-bit two's complement). The
// walk moves +1 when the fraction is below the up-probability and -1
// otherwise, saturating at +/-HALF_RANGE. The up-probability is one half,
// shifted up by bias when only drive A holds (position DELAY_A steps back at
// most threshold) and down by bias when only drive B holds (position DELAY_B
// steps back at least minus threshold). History lives in a row of cells, one
// per past position, shifting once per accepted word. One word is taken per
// clock while the output side keeps taking words: the whole step is
// combinational logic from the newest cell back into it, and the result is
// registered in the cycle after the accept. A single output register holds
// the result; while it is full and not taken, input is stalled. History
// resets to zeros with the newest position at one; threshold resets to 0 and
// bias to 32440. Configuration writes (index 0: threshold, index 1: bias,
// others ignored) are always accepted and must be made while the block idles.
module delayed_feedback_random_walk
    import dfrw_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [15:0] random_fraction
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [4:0] position, [7:5] zero
    // configuration write
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic [OUT_W-1:0] m_pos_reg;
    logic [OUT_W-1:0] m_pos_next;

    pos_t       hist [HIST_DEPTH];
    pos_t       pos_new;
    step_stat_t stat;
    logic       accept;

    // Configuration: always ready; unknown indexes drop silently
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_THRESHOLD: cfg_next.threshold = cfg_data[THR_W-1:0];
                REG_BIAS:      cfg_next.bias      = cfg_data[BIAS_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.threshold <= THR_RESET;
            cfg_reg.bias      <= BIAS_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Accept whenever the output register is empty or being drained
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // History row: the newest cell takes the new position, the rest shift on
    for (genvar k = 0; k < HIST_DEPTH; k++) begin : g_hist
        pos_t cell_in;
        pos_t cell_rst;
        if (k == 0) begin : g_head
            assign cell_in  = pos_new;
            assign cell_rst = POS_W'(1);
        end else begin : g_body
            assign cell_in  = hist[k-1];
            assign cell_rst = '0;
        end
        dfrw_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .shift_en  (accept),
            .rst_value (cell_rst),
            .d_in      (cell_in),
            .q_out     (hist[k])
        );
    end

    dfrw_step u_step (
        .cfg       (cfg_reg),
        .frac      (s_tdata[FRAC_W-1:0]),
        .pos_now   (hist[0]),
        .pos_dly_a (hist[DELAY_A]),
        .pos_dly_b (hist[DELAY_B]),
        .pos_new   (pos_new),
        .stat      (stat)
    );

    // Output register: load on accept, drop when taken
    always_comb begin
        m_valid_next = m_valid_reg;
        m_pos_next   = m_pos_reg;
        if (accept) begin
            m_valid_next = 1'b1;
            m_pos_next   = OUT_W'(pos_new);
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_pos_reg <= m_pos_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - OUT_W){1'b0}}, m_pos_reg};

    // Position never leaves the walk range
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ((POS_W + 1)'(hist[0]) <= POS_MAX_WIDE) && ((POS_W + 1)'(hist[0]) >= POS_MIN_WIDE))
        else $error("walk position out of range");

    // An accepted up step below the upper rail moves the newest position up by one
    a_step_dir: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && stat.step_up && ((POS_W + 1)'(hist[0]) != POS_MAX_WIDE)
        |=> (hist[0] == $past(hist[0]) + POS_W'(1)))
        else $error("up step not taken");

    // The output word after an accept is the new newest position
    a_out_match: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_tvalid && (m_pos_reg == OUT_W'(hist[0])))
        else $error("output word does not match history head");

    // The newest position holds while nothing is accepted
    a_hist_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(hist[0]))
        else $error("history moved without an accepted word");

endmodule

// ===== tb/tb.sv =====
// Testbench for the delayed-feedback random walk: directed plan, random phases, live prediction.
`timescale 1ns / 1ps
module tb
    import dfrw_pkg::*;
();

    // Generous ceiling: about 420 words with their random waits,
    // plus the register writes and their settling gaps.
    localparam int CYCLE_LIMIT  = 40000;
    localparam int SETTLE_CYCLES = 3;
    localparam int PHASE_WORDS  = 50;
    localparam int PHASE_COUNT  = 8;
    localparam int PLAN_ROWS    = 25;

    // Indexes outside the register map: writes to these must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = '1;

    typedef enum logic {ROW_STEP, ROW_WRITE} row_kind_t;

    // One row of the directed plan. For a step row, value is the fraction;
    // typed marks rows whose position is written out by hand.
    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
        logic                  typed;
        logic [OUT_W-1:0]      position;
    } plan_row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Predictor state: past positions (entry 0 newest) and register copies
    int                walk_hist [HIST_DEPTH];
    logic [THR_W-1:0]  walk_threshold;
    logic [BIAS_W-1:0] walk_bias;

    logic [OUT_W-1:0] expected_positions [$];
    int               error_count = 0;
    int               cycle_count = 0;
    int               source_calm = 0;
    int               sink_calm   = 0;
    bit               climb       = 1'b1;

    // Directed plan: climb to the upper rail and sit on it, step down, then
    // exercise the register decode and the exact probability boundaries.
    plan_row_t directed_plan [0:PLAN_ROWS-1] = '{
        '{ROW_STEP,  '0,              16'd0,     1'b1, 5'd2},
        '{ROW_STEP,  '0,              16'd0,     1'b1, 5'd3},
        '{ROW_STEP,  '0,              16'd0,     1'b1, 5'd4},
        '{ROW_STEP,  '0,              16'd0,     1'b1, 5'd5},
        '{ROW_STEP,  '0,              16'd0,     1'b1, 5'd6},
        '{ROW_STEP,  '0,              16'd0,     1'b1, 5'd7},
        '{ROW_STEP,  '0,              16'd0,     1'b1, 5'd8},
        '{ROW_STEP,  '0,              16'd0,     1'b1, 5'd9},
        '{ROW_STEP,  '0,              16'd0,     1'b1, 5'd10},
        '{ROW_STEP,  '0,              16'd0,     1'b1, 5'd10},
        '{ROW_STEP,  '0,              16'hFFFF,  1'b1, 5'd9},
        '{ROW_STEP,  '0,              16'hFFFF,  1'b1, 5'd8},
        // full-width data: bits above each register must be dropped
        '{ROW_WRITE, REG_THRESHOLD,   16'hFFFF,  1'b0, '0},
        '{ROW_WRITE, REG_BIAS,        16'hFFFF,  1'b0, '0},
        '{ROW_WRITE, REG_UNMAPPED_LO, 16'h0000,  1'b0, '0},
        '{ROW_WRITE, REG_UNMAPPED_HI, 16'h0000,  1'b0, '0},
        // threshold 63: both drives hold, so the split sits at one half
        '{ROW_STEP,  '0,              16'd32767, 1'b1, 5'd9},
        '{ROW_STEP,  '0,              16'd32768, 1'b1, 5'd8},
        '{ROW_WRITE, REG_THRESHOLD,   16'h0000,  1'b0, '0},
        '{ROW_STEP,  '0,              16'd0,     1'b0, '0},
        '{ROW_STEP,  '0,              16'd1,     1'b0, '0},
        '{ROW_STEP,  '0,              16'hFFFF,  1'b0, '0},
        '{ROW_WRITE, REG_BIAS,        16'h0000,  1'b0, '0},
        '{ROW_STEP,  '0,              16'd32767, 1'b0, '0},
        '{ROW_STEP,  '0,              16'd32768, 1'b0, '0}
    };

    delayed_feedback_random_walk uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    // Hard stop if the stream locks up
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // Advance the walk by one step and return the new position's low bits
    function automatic logic [OUT_W-1:0] advance_walk(input logic [FRAC_W-1:0] frac);
        logic              drive_a;
        logic              drive_b;
        logic [PROB_W-1:0] up_prob;
        int                next_pos;
        drive_a = walk_hist[DELAY_A] <= int'(walk_threshold);
        drive_b = walk_hist[DELAY_B] >= -int'(walk_threshold);
        up_prob = HALF_PROB;
        if (drive_a && !drive_b) begin
            up_prob = HALF_PROB + PROB_W'(walk_bias);
        end else if (drive_b && !drive_a) begin
            up_prob = HALF_PROB - PROB_W'(walk_bias);
        end
        next_pos = walk_hist[0];
        // 17-bit compare: the up-probability is at most 65535, so a fraction of all ones never steps up
        if ({1'b0, frac} < up_prob) begin
            next_pos = (next_pos >= HALF_RANGE) ? HALF_RANGE : next_pos + 1;
        end else begin
            next_pos = (next_pos <= -HALF_RANGE) ? -HALF_RANGE : next_pos - 1;
        end
        for (int k = HIST_DEPTH - 1; k > 0; k--) begin
            walk_hist[k] = walk_hist[k - 1];
        end
        walk_hist[0] = next_pos;
        return OUT_W'(next_pos);
    endfunction

    // Per-word wait: mostly a random wait, with occasional runs of no waiting
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm_left = $urandom_range(20, 40);
            return 0;
        end
        return $urandom_range(0, 4);
    endfunction

    // Mix of uniform fractions, values on the probability cuts, and streaks
    // of a rail value that push the walk into saturation at either end
    function automatic logic [FRAC_W-1:0] pick_fraction();
        int pick;
        int cut;
        pick = $urandom_range(0, 9);
        if ($urandom_range(0, 7) == 0) begin
            climb = !climb;
        end
        if (pick < 5) begin
            return FRAC_W'($urandom);
        end
        if (pick < 7) begin
            case ($urandom_range(0, 2))
                0: begin
                    cut = int'(HALF_PROB);
                end
                1: begin
                    cut = int'(HALF_PROB) + int'(walk_bias);
                end
                default: begin
                    cut = int'(HALF_PROB) - int'(walk_bias);
                end
            endcase
            cut = cut - int'($urandom_range(0, 1));
            if (cut > 65535) begin
                cut = 65535;
            end
            if (cut < 0) begin
                cut = 0;
            end
            return FRAC_W'(cut);
        end
        return climb ? '0 : '1;
    endfunction

    // Offer one fraction; predict at the accepting edge
    task automatic send_fraction(input logic [FRAC_W-1:0] frac, input logic typed,
                                 input logic [OUT_W-1:0] typed_pos);
        int               gap;
        logic [OUT_W-1:0] predicted;
        gap = draw_wait(source_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= frac;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        predicted = advance_walk(frac);
        expected_positions.push_back(typed ? typed_pos : predicted);
    endtask

    // Hold input, let every expected word arrive, then let the pipe settle
    task automatic drain_walk();
        s_tvalid <= 1'b0;
        while (expected_positions.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        // mirror the decode: unknown indexes drop, excess bits drop
        if (idx == REG_THRESHOLD) begin
            walk_threshold = value[THR_W-1:0];
        end else if (idx == REG_BIAS) begin
            walk_bias = value[BIAS_W-1:0];
        end
    endtask

    // Result side: stall at random, check every accepted word in order
    initial begin : result_sink
        int               stall;
        logic [OUT_W-1:0] want;
        wait (aresetn === 1'b1);
        forever begin
            stall = draw_wait(sink_calm);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            if (expected_positions.size() == 0) begin
                error_count++;
                $error("position: expected none, got %0d", $signed(m_tdata[OUT_W-1:0]));
            end else begin
                want = expected_positions.pop_front();
                if (m_tdata[OUT_W-1:0] !== want) begin
                    error_count++;
                    $error("position: expected %0d, got %0d",
                           $signed(want), $signed(m_tdata[OUT_W-1:0]));
                end
                if (m_tdata[M_TDATA_W-1:OUT_W] !== '0) begin
                    error_count++;
                    $error("padding: expected 0, got %0d", m_tdata[M_TDATA_W-1:OUT_W]);
                end
            end
        end
    end

    // Stimulus: reset, directed plan, then random phases under fresh settings
    initial begin : stimulus
        logic [CFG_DATA_W-1:0] phase_thr;
        logic [CFG_DATA_W-1:0] phase_bias;
        for (int k = 0; k < HIST_DEPTH; k++) begin
            walk_hist[k] = 0;
        end
        walk_hist[0]   = 1;
        walk_threshold = THR_RESET;
        walk_bias      = BIAS_RESET;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_plan[r]) begin
            if (directed_plan[r].kind == ROW_WRITE) begin
                drain_walk();
                write_register(directed_plan[r].index, directed_plan[r].value);
            end else begin
                send_fraction(directed_plan[r].value[FRAC_W-1:0], directed_plan[r].typed,
                              directed_plan[r].position);
            end
        end

        for (int p = 0; p < PHASE_COUNT; p++) begin
            // fixed corner settings first, then random ones with full-width data
            case (p)
                0: begin
                    phase_thr  = CFG_DATA_W'(THR_RESET);
                    phase_bias = CFG_DATA_W'(BIAS_RESET);
                end
                1: begin
                    phase_thr  = 16'd63;
                    phase_bias = 16'd32767;
                end
                2: begin
                    phase_thr  = 16'd0;
                    phase_bias = 16'd0;
                end
                3: begin
                    phase_thr  = 16'd1;
                    phase_bias = 16'd32767;
                end
                4: begin
                    phase_thr  = 16'd5;
                    phase_bias = 16'd16384;
                end
                default: begin
                    phase_thr  = (CFG_DATA_W'($urandom) & 16'hFFC0)
                                 | CFG_DATA_W'($urandom_range(0, 12));
                    phase_bias = CFG_DATA_W'($urandom);
                end
            endcase
            drain_walk();
            write_register(REG_THRESHOLD, phase_thr);
            @(posedge aclk);
            write_register(REG_BIAS, phase_bias);
            repeat (PHASE_WORDS) send_fraction(pick_fraction(), 1'b0, '0);
        end

        drain_walk();
        repeat (8) @(posedge aclk);
        if (error_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
